FILE: hw/rtl/dmck_pkg.sv
// Shared types, constants and helper function of the dual Monod cell kinetics block.
package dmck_pkg;

  localparam int QBITS      = 25;
  localparam int DIV_STAGES = 25;

  localparam logic [20:0] POINT_ONE_Q24 = 21'd1677722;
  localparam logic [14:0] DISSOLVE_Q32  = 15'd18898;
  localparam logic [30:0] ONE_Q24       = 31'd16777216;

  typedef enum logic [2:0] {
    REG_MAX_GROWTH   = 3'd0,
    REG_INV_YIELD    = 3'd1,
    REG_H2_HALF_SAT  = 3'd2,
    REG_CO2_HALF_SAT = 3'd3,
    REG_MAINTENANCE  = 3'd4,
    REG_DECAY        = 3'd5,
    REG_EPS_RATIO    = 3'd6,
    REG_GAS_ENABLE   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] rem_h2;
    logic [31:0] den_h2;
    logic [QBITS-1:0] q_h2;
    logic        zero_h2;
    logic [31:0] rem_co2;
    logic [31:0] den_co2;
    logic [QBITS-1:0] q_co2;
    logic        zero_co2;
    logic [30:0] conc_co2;
    logic [30:0] conc_gas_co2;
    logic [30:0] biomass;
    logic [31:0] r_h2;
    logic [31:0] r_co2;
    logic [31:0] r_ch4;
    logic        ghost;
  } div_stage_t;

  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    logic [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (v < -49'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/dual_monod_cell_kinetics.sv
// Top level of the dual Monod cell kinetics block: restoring divider pipeline and product stages.
// The block accepts one grid cell in every clock cycle and never asserts busy. Each cell's
// result is on the result ports for exactly one cycle, marked by result_valid, once it has
// passed the 25-stage restoring divider pipeline that forms both saturation fractions, one
// quotient bit per stage, and the six multiply and accumulate stages after it. The receiver
// cannot stall the block, so results must be taken as they appear. Configuration registers
// may be written only while no cell is in flight.
module dual_monod_cell_kinetics (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] conc_h2,
  input  logic [30:0] conc_co2,
  input  logic [30:0] conc_gas_co2,
  input  logic [30:0] biomass_density,
  input  logic [31:0] reaction_h2_in,
  input  logic [31:0] reaction_co2_in,
  input  logic [31:0] reaction_ch4_in,
  input  logic        ghost_cell,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [31:0] reaction_h2_out,
  output logic [31:0] reaction_co2_out,
  output logic [31:0] reaction_ch4_out,
  output logic [31:0] net_growth,
  output logic [31:0] eps_growth
);

  logic [30:0] max_growth_rate;
  logic [30:0] inverse_yield;
  logic [30:0] h2_half_saturation;
  logic [30:0] co2_half_saturation;
  logic [30:0] maintenance_rate;
  logic [30:0] decay_rate;
  logic [30:0] eps_yield_ratio;
  logic        gas_dissolution_enable;

  dmck_pkg::div_stage_t div [0:dmck_pkg::DIV_STAGES];

  logic        a_valid;
  logic [31:0] a_partial;
  logic [37:0] a_maint;
  logic signed [15:0] a_diss;
  logic [dmck_pkg::QBITS-1:0] a_fco2;
  logic [30:0] a_biomass;
  logic [31:0] a_r_h2, a_r_co2, a_r_ch4;
  logic        a_ghost;

  logic        b_valid;
  logic [30:0] b_mu;
  logic [34:0] b_drain;
  logic signed [15:0] b_diss;
  logic [30:0] b_biomass;
  logic [31:0] b_r_h2, b_r_co2, b_r_ch4;
  logic        b_ghost;

  logic        c_valid;
  logic [37:0] c_iy;
  logic [31:0] c_eps;
  logic [31:0] c_net;
  logic [34:0] c_drain;
  logic signed [15:0] c_diss;
  logic [30:0] c_biomass;
  logic [31:0] c_r_h2, c_r_co2, c_r_ch4;
  logic        c_ghost;

  logic        d_valid;
  logic [44:0] d_ph;
  logic [54:0] d_pl;
  logic [31:0] d_eps, d_net;
  logic [34:0] d_drain;
  logic signed [15:0] d_diss;
  logic [31:0] d_r_h2, d_r_co2, d_r_ch4;
  logic        d_ghost;

  logic        e_valid;
  logic [45:0] e_uptake;
  logic [31:0] e_eps, e_net;
  logic [34:0] e_drain;
  logic signed [15:0] e_diss;
  logic [31:0] e_r_h2, e_r_co2, e_r_ch4;
  logic        e_ghost;

  logic [dmck_pkg::QBITS-1:0] fh2;
  logic [dmck_pkg::QBITS-1:0] fco2;
  logic [55:0] prod_a;
  logic [61:0] prod_m;
  logic signed [31:0] diff;
  logic [31:0] mag;
  logic [46:0] prod_d;
  logic [56:0] prod_mu;
  logic [58:0] prod_dr;
  logic [61:0] prod_iy;
  logic [61:0] prod_eps;
  logic signed [33:0] net_wide;
  logic signed [48:0] sum_h2, sum_co2, sum_ch4;

  function automatic dmck_pkg::div_stage_t div_step(input dmck_pkg::div_stage_t s,
                                                      input logic first,
                                                      input logic kill);
    dmck_pkg::div_stage_t n;
    logic [32:0] th;
    logic [32:0] tc;
    n = s;
    n.valid = s.valid && !kill;
    th = first ? {1'b0, s.rem_h2} : {s.rem_h2, 1'b0};
    tc = first ? {1'b0, s.rem_co2} : {s.rem_co2, 1'b0};
    if (th >= {1'b0, s.den_h2}) begin
      th = th - {1'b0, s.den_h2};
      n.q_h2 = {s.q_h2[dmck_pkg::QBITS-2:0], 1'b1};
    end else begin
      n.q_h2 = {s.q_h2[dmck_pkg::QBITS-2:0], 1'b0};
    end
    if (tc >= {1'b0, s.den_co2}) begin
      tc = tc - {1'b0, s.den_co2};
      n.q_co2 = {s.q_co2[dmck_pkg::QBITS-2:0], 1'b1};
    end else begin
      n.q_co2 = {s.q_co2[dmck_pkg::QBITS-2:0], 1'b0};
    end
    n.rem_h2 = th[31:0];
    n.rem_co2 = tc[31:0];
    return n;
  endfunction

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_growth_rate        <= '0;
      inverse_yield          <= dmck_pkg::ONE_Q24;
      h2_half_saturation     <= '0;
      co2_half_saturation    <= '0;
      maintenance_rate       <= '0;
      decay_rate             <= '0;
      eps_yield_ratio        <= '0;
      gas_dissolution_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (dmck_pkg::reg_index_t'(cfg_index))
        dmck_pkg::REG_MAX_GROWTH:   max_growth_rate <= cfg_data[30:0];
        dmck_pkg::REG_INV_YIELD:    inverse_yield <= cfg_data[30:0];
        dmck_pkg::REG_H2_HALF_SAT:  h2_half_saturation <= cfg_data[30:0];
        dmck_pkg::REG_CO2_HALF_SAT: co2_half_saturation <= cfg_data[30:0];
        dmck_pkg::REG_MAINTENANCE:  maintenance_rate <= cfg_data[30:0];
        dmck_pkg::REG_DECAY:        decay_rate <= cfg_data[30:0];
        dmck_pkg::REG_EPS_RATIO:    eps_yield_ratio <= cfg_data[30:0];
        dmck_pkg::REG_GAS_ENABLE:   gas_dissolution_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    div[0].valid        <= start && !busy && !rst;
    div[0].den_h2       <= {1'b0, h2_half_saturation} + {1'b0, conc_h2};
    div[0].rem_h2       <= {1'b0, conc_h2};
    div[0].q_h2         <= '0;
    div[0].zero_h2      <= (h2_half_saturation == '0) && (conc_h2 == '0);
    div[0].den_co2      <= {1'b0, co2_half_saturation} + {1'b0, conc_co2};
    div[0].rem_co2      <= {1'b0, conc_co2};
    div[0].q_co2        <= '0;
    div[0].zero_co2     <= (co2_half_saturation == '0) && (conc_co2 == '0);
    div[0].conc_co2     <= conc_co2;
    div[0].conc_gas_co2 <= conc_gas_co2;
    div[0].biomass      <= biomass_density;
    div[0].r_h2         <= reaction_h2_in;
    div[0].r_co2        <= reaction_co2_in;
    div[0].r_ch4        <= reaction_ch4_in;
    div[0].ghost        <= ghost_cell;
    for (int k = 1; k <= dmck_pkg::DIV_STAGES; k++) begin
      div[k] <= div_step(div[k-1], k == 1, rst);
    end
  end

  always_comb begin
    fh2 = div[dmck_pkg::DIV_STAGES].zero_h2 ? '0 : div[dmck_pkg::DIV_STAGES].q_h2;
    fco2 = div[dmck_pkg::DIV_STAGES].zero_co2 ? '0 : div[dmck_pkg::DIV_STAGES].q_co2;
    prod_a = {25'd0, max_growth_rate} * {31'd0, fh2};
    prod_m = {31'd0, maintenance_rate} * {31'd0, div[dmck_pkg::DIV_STAGES].biomass};
    diff = $signed({1'b0, div[dmck_pkg::DIV_STAGES].conc_gas_co2})
         - $signed({1'b0, div[dmck_pkg::DIV_STAGES].conc_co2});
    mag = diff[31] ? 32'(-diff) : 32'(diff);
    prod_d = {15'd0, mag} * {32'd0, dmck_pkg::DISSOLVE_Q32};
    prod_mu = {25'd0, a_partial} * {32'd0, a_fco2};
    prod_dr = {21'd0, a_maint} * {38'd0, dmck_pkg::POINT_ONE_Q24};
    prod_iy = {31'd0, inverse_yield} * {31'd0, b_mu};
    prod_eps = {31'd0, eps_yield_ratio} * {31'd0, b_mu};
    net_wide = $signed({3'b0, b_mu}) - $signed({3'b0, decay_rate})
             - $signed({3'b0, maintenance_rate});
    sum_h2 = $signed({{17{e_r_h2[31]}}, e_r_h2}) - $signed({3'b0, e_uptake});
    sum_co2 = $signed({{17{e_r_co2[31]}}, e_r_co2}) - $signed({3'b0, e_uptake})
            + $signed({{33{e_diss[15]}}, e_diss});
    sum_ch4 = $signed({{17{e_r_ch4[31]}}, e_r_ch4}) - $signed({14'b0, e_drain})
            + $signed({3'b0, e_uptake});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      a_valid <= div[dmck_pkg::DIV_STAGES].valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      result_valid <= e_valid;
    end

    a_partial <= prod_a[55:24];
    a_maint   <= prod_m[61:24];
    a_diss    <= gas_dissolution_enable ?
                 (diff[31] ? -$signed({1'b0, prod_d[46:32]}) : $signed({1'b0, prod_d[46:32]}))
                 : 16'sd0;
    a_fco2    <= fco2;
    a_biomass <= div[dmck_pkg::DIV_STAGES].biomass;
    a_r_h2    <= div[dmck_pkg::DIV_STAGES].r_h2;
    a_r_co2   <= div[dmck_pkg::DIV_STAGES].r_co2;
    a_r_ch4   <= div[dmck_pkg::DIV_STAGES].r_ch4;
    a_ghost   <= div[dmck_pkg::DIV_STAGES].ghost;

    b_mu      <= prod_mu[54:24];
    b_drain   <= prod_dr[58:24];
    b_diss    <= a_diss;
    b_biomass <= a_biomass;
    b_r_h2    <= a_r_h2;
    b_r_co2   <= a_r_co2;
    b_r_ch4   <= a_r_ch4;
    b_ghost   <= a_ghost;

    c_iy      <= prod_iy[61:24];
    c_eps     <= (prod_eps[61:24] > 38'h007fffffff) ? 32'h7fffffff : {1'b0, prod_eps[54:24]};
    c_net     <= dmck_pkg::sat32(49'(net_wide));
    c_drain   <= b_drain;
    c_diss    <= b_diss;
    c_biomass <= b_biomass;
    c_r_h2    <= b_r_h2;
    c_r_co2   <= b_r_co2;
    c_r_ch4   <= b_r_ch4;
    c_ghost   <= b_ghost;

    d_ph      <= c_iy[37:24] * c_biomass;
    d_pl      <= c_iy[23:0] * c_biomass;
    d_eps     <= c_eps;
    d_net     <= c_net;
    d_drain   <= c_drain;
    d_diss    <= c_diss;
    d_r_h2    <= c_r_h2;
    d_r_co2   <= c_r_co2;
    d_r_ch4   <= c_r_ch4;
    d_ghost   <= c_ghost;

    e_uptake  <= {1'b0, d_ph} + {15'd0, d_pl[54:24]};
    e_eps     <= d_eps;
    e_net     <= d_net;
    e_drain   <= d_drain;
    e_diss    <= d_diss;
    e_r_h2    <= d_r_h2;
    e_r_co2   <= d_r_co2;
    e_r_ch4   <= d_r_ch4;
    e_ghost   <= d_ghost;

    reaction_h2_out  <= e_ghost ? e_r_h2 : dmck_pkg::sat32(sum_h2);
    reaction_co2_out <= e_ghost ? e_r_co2 : dmck_pkg::sat32(sum_co2);
    reaction_ch4_out <= e_ghost ? e_r_ch4 : dmck_pkg::sat32(sum_ch4);
    net_growth       <= e_net;
    eps_growth       <= e_eps;
  end

endmodule
